/* hdl/pngu_pkg.sv */
// Shared constants and types for the PNG scanline unfilter.
package pngu_pkg;

	// Default sizing, handed to the top-level parameters.
	localparam int unsigned MAX_WIDTH_DEF    = 1024;
	localparam int unsigned MAX_HEIGHT_DEF   = 1024;
	localparam int unsigned PALETTE_SIZE_DEF = 256;

	// Configuration port.
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 11;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COLOR_MODE   = 2'd0,
		CFG_IMAGE_WIDTH  = 2'd1,
		CFG_IMAGE_HEIGHT = 2'd2
	} cfg_reg_t;

	// Color modes; code 3 is treated as RGBA.
	localparam logic [1:0] MODE_PALETTE = 2'd0;
	localparam logic [1:0] MODE_RGB     = 2'd1;
	localparam logic [1:0] MODE_RGBA    = 2'd2;

	// Row filter codes.
	localparam logic [2:0] FILT_NONE  = 3'd0;
	localparam logic [2:0] FILT_SUB   = 3'd1;
	localparam logic [2:0] FILT_UP    = 3'd2;
	localparam logic [2:0] FILT_AVG   = 3'd3;
	localparam logic [2:0] FILT_PAETH = 3'd4;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

	// Register reset values.
	localparam logic [1:0]            COLOR_MODE_RST   = MODE_RGBA;
	localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RST  = 11'd1024;
	localparam logic [CFG_DATA_W-1:0] IMAGE_HEIGHT_RST = 11'd1024;

	// Raster position flags for one pixel.
	typedef struct packed {
		logic first_row;
		logic first_col;
		logic row_end;
		logic image_end;
	} scan_flags_t;

endpackage

/* hdl/pngu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pngu_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Read returns the old contents on a same-address write.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hdl/pngu_scan.sv */
// Column and row counters with row and image end detection.
module pngu_scan #(
	parameter int unsigned MAX_WIDTH  = pngu_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = pngu_pkg::MAX_HEIGHT_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         step,
	input  logic [pngu_pkg::CFG_DATA_W-1:0]              image_width,
	input  logic [pngu_pkg::CFG_DATA_W-1:0]              image_height,
	output logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0] col,
	output pngu_pkg::scan_flags_t                        flags
);

	localparam int unsigned CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int unsigned XW0 = $clog2(MAX_WIDTH + 1);
	localparam int unsigned YW0 = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned XW  = (XW0 > pngu_pkg::CFG_DATA_W) ? XW0 : pngu_pkg::CFG_DATA_W;
	localparam int unsigned YW  = (YW0 > pngu_pkg::CFG_DATA_W) ? YW0 : pngu_pkg::CFG_DATA_W;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [XW-1:0] w_raw, w_eff;
	logic [YW-1:0] h_raw, h_eff;
	logic          rend, iend;

	// Clamp the programmed size to 1..MAX.
	always_comb begin
		w_raw = XW'(image_width);
		h_raw = YW'(image_height);
		if (w_raw == '0) begin
			w_eff = XW'(1);
		end else if (w_raw > XW'(MAX_WIDTH)) begin
			w_eff = XW'(MAX_WIDTH);
		end else begin
			w_eff = w_raw;
		end
		if (h_raw == '0) begin
			h_eff = YW'(1);
		end else if (h_raw > YW'(MAX_HEIGHT)) begin
			h_eff = YW'(MAX_HEIGHT);
		end else begin
			h_eff = h_raw;
		end
	end

	// >= so a shrunk size mid-image ends the row on the next pixel
	assign rend = (XW'(col_q) + XW'(1)) >= w_eff;
	assign iend = rend && ((YW'(row_q) + YW'(1)) >= h_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if (rend) begin
				col_q <= '0;
				row_q <= iend ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	assign col             = col_q;
	assign flags.first_row = (row_q == '0);
	assign flags.first_col = (col_q == '0);
	assign flags.row_end   = rend;
	assign flags.image_end = iend;

endmodule

/* hdl/pngu_recon.sv */
// Per-lane inverse of the PNG row filters for one pixel.
module pngu_recon (
	input  logic [1:0]  color_mode,
	input  logic [2:0]  filter_type,
	input  logic [31:0] raw,
	input  logic [31:0] left,
	input  logic [31:0] up,
	input  logic [31:0] upper_left,
	output logic [31:0] rec,
	output logic        bad
);

	function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic signed [10:0] p, da, db, dc;
		p  = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({3'b000, c});
		da = p - $signed({3'b000, a});
		db = p - $signed({3'b000, b});
		dc = p - $signed({3'b000, c});
		if (da < 0) da = -da;
		if (db < 0) db = -db;
		if (dc < 0) dc = -dc;
		if (da <= db && da <= dc) begin
			return a;
		end else if (db <= dc) begin
			return b;
		end else begin
			return c;
		end
	endfunction

	function automatic logic [7:0] undo_lane(input logic [2:0] f, input logic [7:0] r,
			input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
		logic [7:0] pred;
		logic [8:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		unique case (f)
			pngu_pkg::FILT_SUB:   pred = a;
			pngu_pkg::FILT_UP:    pred = b;
			pngu_pkg::FILT_AVG:   pred = sum[8:1];
			pngu_pkg::FILT_PAETH: pred = paeth_pick(a, b, c);
			default:              pred = 8'd0;
		endcase
		return r + pred;
	endfunction

	logic [2:0] f_eff;
	logic [3:0] lane_on;
	logic       is_rgb;

	assign bad    = filter_type > pngu_pkg::FILT_PAETH;
	assign f_eff  = bad ? pngu_pkg::FILT_NONE : filter_type;
	assign is_rgb = (color_mode == pngu_pkg::MODE_RGB);

	// Palette filters the index lane only; RGB leaves alpha out.
	assign lane_on[0] = 1'b1;
	assign lane_on[1] = (color_mode != pngu_pkg::MODE_PALETTE);
	assign lane_on[2] = (color_mode != pngu_pkg::MODE_PALETTE);
	assign lane_on[3] = (color_mode != pngu_pkg::MODE_PALETTE) && !is_rgb;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			if (lane_on[k]) begin
				rec[8*k +: 8] = undo_lane(f_eff, raw[8*k +: 8], left[8*k +: 8],
					up[8*k +: 8], upper_left[8*k +: 8]);
			end else if (k == 3 && is_rgb) begin
				rec[8*k +: 8] = pngu_pkg::ALPHA_OPAQUE;
			end else begin
				rec[8*k +: 8] = 8'd0;
			end
		end
	end

endmodule

/* hdl/png_scanline_unfilter.sv */
// PNG scanline unfilter top level: handshakes, line store, palette, result register.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------------
//   in       | in_valid / in_stall  | cmd, filter_type, byte_red..byte_alpha, entry_index
//   out      | out_valid / out_stall| out_red..out_alpha, row_end, image_end, bad_filter
//   cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// One item per clock sustained while out is not stalled; the left-neighbor loop is
// one filter adder plus the Paeth compare. Accept loads the input stage (line
// store read lands there); adv moves it into the result register, where out_valid
// rises together with the palette read. Palette writes finish at accept.
// Reset clears counters, palette valid bits and the line store fill count.
// in_stall is high only while both stages are full and out is stalled.
module png_scanline_unfilter #(
	parameter int unsigned MAX_WIDTH    = pngu_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT   = pngu_pkg::MAX_HEIGHT_DEF,
	parameter int unsigned PALETTE_SIZE = pngu_pkg::PALETTE_SIZE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pngu_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pngu_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input items
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             cmd,
	input  logic [2:0]                       filter_type,
	input  logic [7:0]                       byte_red,
	input  logic [7:0]                       byte_green,
	input  logic [7:0]                       byte_blue,
	input  logic [7:0]                       byte_alpha,
	input  logic [7:0]                       entry_index,
	// results
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [7:0]                       out_red,
	output logic [7:0]                       out_green,
	output logic [7:0]                       out_blue,
	output logic [7:0]                       out_alpha,
	output logic                             row_end,
	output logic                             image_end,
	output logic                             bad_filter
);

	localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned FW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned PW = $clog2(PALETTE_SIZE);

	// ---------------- configuration registers ----------------
	logic [1:0]                        color_mode_q;
	logic [pngu_pkg::CFG_DATA_W-1:0]   image_width_q;
	logic [pngu_pkg::CFG_DATA_W-1:0]   image_height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q   <= pngu_pkg::COLOR_MODE_RST;
			image_width_q  <= pngu_pkg::IMAGE_WIDTH_RST;
			image_height_q <= pngu_pkg::IMAGE_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (pngu_pkg::cfg_reg_t'(cfg_index))
				pngu_pkg::CFG_COLOR_MODE:   color_mode_q   <= cfg_data[1:0];
				pngu_pkg::CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				pngu_pkg::CFG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- handshake and stage control ----------------
	logic s1_valid_q;   // input stage holds a pixel
	logic adv;          // input stage moves into the result register
	logic in_fire, pix_fire, pal_we;

	assign adv      = s1_valid_q && (!out_valid || !out_stall);
	assign in_stall = s1_valid_q && !adv;
	assign in_fire  = in_valid && !in_stall;
	assign pix_fire = in_fire && cmd;
	assign pal_we   = in_fire && !cmd && ({1'b0, entry_index} < 9'(PALETTE_SIZE));

	// ---------------- raster position ----------------
	logic [CW-1:0]         scan_col;
	pngu_pkg::scan_flags_t scan_flags;

	pngu_scan #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (pix_fire),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.col          (scan_col),
		.flags        (scan_flags)
	);

	// ---------------- line store (row above) ----------------
	// Columns are always written in order from 0, so a fill count marks which
	// entries hold data since reset; the rest read as zero.
	logic [FW-1:0]  fill_q;
	logic [CW-1:0]  col_s1;
	logic [31:0]    rec;
	logic [31:0]    line_rdata;

	pngu_ram #(
		.WIDTH (32),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (adv),
		.waddr (col_s1),
		.wdata (rec),
		.re    (pix_fire),
		.raddr (scan_col),
		.rdata (line_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (adv && (FW'(col_s1) >= fill_q)) begin
			fill_q <= FW'(col_s1) + FW'(1);
		end
	end

	// ---------------- input stage ----------------
	logic [2:0]            filt_s1;
	logic [31:0]           raw_s1;
	pngu_pkg::scan_flags_t flags_s1;
	logic                  line_ok_s1;   // entry written since reset
	logic                  fwd_s1;       // same column written on the accept edge
	logic [31:0]           fwd_data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (pix_fire) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_fire) begin
			filt_s1     <= filter_type;
			raw_s1      <= {byte_alpha, byte_blue, byte_green, byte_red};
			col_s1      <= scan_col;
			flags_s1    <= scan_flags;
			line_ok_s1  <= (FW'(scan_col) < fill_q);
			fwd_s1      <= adv && (col_s1 == scan_col);
			fwd_data_s1 <= rec;
		end
	end

	// ---------------- neighbors and reconstruction ----------------
	logic [31:0] left_q, upper_left_q;
	logic [31:0] up, left, upper_left;
	logic        bad;

	always_comb begin
		if (flags_s1.first_row) begin
			up = '0;
		end else if (fwd_s1) begin
			up = fwd_data_s1;
		end else if (line_ok_s1) begin
			up = line_rdata;
		end else begin
			up = '0;
		end
	end

	assign left       = flags_s1.first_col ? '0 : left_q;
	assign upper_left = (flags_s1.first_col || flags_s1.first_row) ? '0 : upper_left_q;

	pngu_recon u_recon (
		.color_mode  (color_mode_q),
		.filter_type (filt_s1),
		.raw         (raw_s1),
		.left        (left),
		.up          (up),
		.upper_left  (upper_left),
		.rec         (rec),
		.bad         (bad)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			left_q       <= rec;
			upper_left_q <= up;
		end
	end

	// ---------------- palette ----------------
	logic [PALETTE_SIZE-1:0] pal_valid_q;
	logic [31:0]             pal_rdata;
	logic                    pal_in_range;

	pngu_ram #(
		.WIDTH (32),
		.DEPTH (PALETTE_SIZE)
	) u_pal_ram (
		.clk   (clk),
		.we    (pal_we),
		.waddr (entry_index[PW-1:0]),
		.wdata ({byte_alpha, byte_blue, byte_green, byte_red}),
		.re    (adv),
		.raddr (rec[PW-1:0]),
		.rdata (pal_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_valid_q <= '0;
		end else if (pal_we) begin
			pal_valid_q[entry_index[PW-1:0]] <= 1'b1;
		end
	end

	assign pal_in_range = ({1'b0, rec[7:0]} < 9'(PALETTE_SIZE));

	// ---------------- result register ----------------
	logic [31:0] rec_s2;
	logic        pal_mode_s2, pal_hit_s2;
	logic        row_end_s2, image_end_s2, bad_s2;
	logic [31:0] colour;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rec_s2       <= rec;
			pal_mode_s2  <= (color_mode_q == pngu_pkg::MODE_PALETTE);
			pal_hit_s2   <= pal_in_range && pal_valid_q[rec[PW-1:0]];
			row_end_s2   <= flags_s1.row_end;
			image_end_s2 <= flags_s1.image_end;
			bad_s2       <= bad;
		end
	end

	// palette data register only moves on adv, so it holds while stalled
	assign colour = pal_mode_s2 ? (pal_hit_s2 ? pal_rdata : '0) : rec_s2;

	assign out_red    = colour[7:0];
	assign out_green  = colour[15:8];
	assign out_blue   = colour[23:16];
	assign out_alpha  = colour[31:24];
	assign row_end    = row_end_s2;
	assign image_end  = image_end_s2;
	assign bad_filter = bad_s2;

endmodule

/* dv/png_scanline_unfilter_tb.sv */
// Self-checking testbench for the PNG scanline unfilter: random and directed pixel streams.
module png_scanline_unfilter_tb;

	// Sizing matches the DUT defaults.
	localparam int unsigned MAX_W = pngu_pkg::MAX_WIDTH_DEF;
	localparam int unsigned MAX_H = pngu_pkg::MAX_HEIGHT_DEF;

	// Item kinds on the input channel.
	localparam logic CMD_PALETTE = 1'b0;
	localparam logic CMD_PIXEL   = 1'b1;

	// Reserved filter codes: flagged, pixel passes raw.
	localparam logic [2:0] FILT_RSVD_5 = 3'd5;
	localparam logic [2:0] FILT_RSVD_6 = 3'd6;
	localparam logic [2:0] FILT_RSVD_7 = 3'd7;

	// Codes with no package name: unused register slot and color mode 3.
	localparam logic [pngu_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
	localparam logic [1:0]                     MODE_SPARE    = 2'd3;

	localparam int unsigned ITEM_TARGET  = 1950;
	localparam int unsigned CALM_ITEMS   = 150;  // last stretch, no idling
	localparam int unsigned LONG_HOLD    = 120;  // receiver hold-off, in cycles
	localparam int unsigned HOLD_PHASE   = 2;    // random phase that gets the hold-off
	localparam int unsigned QUIET_LIMIT  = 2000; // cycles with no transfer at all
	localparam int unsigned SETTLE       = 4;    // DUT latency plus margin
	localparam int unsigned REPORT_MAX   = 200;

	typedef struct packed {
		logic       cmd;
		logic [2:0] filt;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [7:0] slot;
	} raw_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       rend;
		logic       iend;
		logic       bad;
	} pixel_t;

	// DUT-facing signals; every input known from time zero.
	logic                            clk         = 1'b0;
	logic                            arst_n      = 1'b0;
	logic                            cfg_valid   = 1'b0;
	logic                            cfg_ready;
	logic [pngu_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [pngu_pkg::CFG_DATA_W-1:0] cfg_data    = '0;
	logic                            in_valid    = 1'b0;
	logic                            in_stall;
	logic                            cmd         = CMD_PIXEL;
	logic [2:0]                      filter_type = pngu_pkg::FILT_NONE;
	logic [7:0]                      byte_red    = '0;
	logic [7:0]                      byte_green  = '0;
	logic [7:0]                      byte_blue   = '0;
	logic [7:0]                      byte_alpha  = '0;
	logic [7:0]                      entry_index = '0;
	logic                            out_valid;
	logic                            out_stall   = 1'b0;
	logic [7:0]                      out_red;
	logic [7:0]                      out_green;
	logic [7:0]                      out_blue;
	logic [7:0]                      out_alpha;
	logic                            row_end;
	logic                            image_end;
	logic                            bad_filter;

	png_scanline_unfilter u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.filter_type (filter_type),
		.byte_red    (byte_red),
		.byte_green  (byte_green),
		.byte_blue   (byte_blue),
		.byte_alpha  (byte_alpha),
		.entry_index (entry_index),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.out_alpha   (out_alpha),
		.row_end     (row_end),
		.image_end   (image_end),
		.bad_filter  (bad_filter)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow copy of the unfilter state, advanced on every accepted transfer.
	// ------------------------------------------------------------------
	logic [1:0]                      cfg_mode;
	logic [pngu_pkg::CFG_DATA_W-1:0] cfg_width;
	logic [pngu_pkg::CFG_DATA_W-1:0] cfg_height;
	logic [31:0]                     above_mem [MAX_W];
	logic [31:0]                     palette_mem [pngu_pkg::PALETTE_SIZE_DEF];
	logic [31:0]                     left_px;
	logic [31:0]                     ul_px;
	int unsigned                     col_cnt;
	int unsigned                     row_cnt;

	raw_item_t   raw_q [$];   // items waiting for the driver
	pixel_t      recon_q [$]; // reconstructed pixels still owed by the DUT

	// Bookkeeping.
	int unsigned n_issued, n_accepted, errors, quiet_cycles;
	int unsigned n_pixels, n_pal_writes, n_rows, n_images, n_bad, n_cfg, n_in_stalled;

	// Traffic shaping shared by driver and receiver.
	bit          idle_on;
	bit          hold_req;
	bit          in_taken;
	int unsigned send_gap;
	int unsigned stall_left;
	raw_item_t   drv_item;

	// One byte lane of the inverse filter, modulo 256.
	function automatic logic [7:0] unfilter_byte(input logic [2:0] f, input logic [7:0] x,
			input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
		logic [7:0] pred;
		int         ia, ib, ic, p, pa, pb, pc;
		ia = int'(a);
		ib = int'(b);
		ic = int'(c);
		case (f)
			pngu_pkg::FILT_SUB: pred = a;
			pngu_pkg::FILT_UP:  pred = b;
			pngu_pkg::FILT_AVG: pred = 8'((9'(a) + 9'(b)) >> 1);
			pngu_pkg::FILT_PAETH: begin
				p  = ia + ib - ic;
				pa = (p > ia) ? p - ia : ia - p;
				pb = (p > ib) ? p - ib : ib - p;
				pc = (p > ic) ? p - ic : ic - p;
				// ties favor left, then up
				if (pa <= pb && pa <= pc)
					pred = a;
				else if (pb <= pc)
					pred = b;
				else
					pred = c;
			end
			default: pred = 8'h00;
		endcase
		return x + pred;
	endfunction

	// Undo the row filter for one pixel, update the neighbors and counters,
	// and queue the pixel the DUT should emit.
	task automatic reconstruct_pixel(input logic [2:0] filt, input logic [31:0] raw);
		logic [31:0] up, lft, ul, rec, colour;
		logic [1:0]  md;
		logic [2:0]  f;
		int unsigned w, h, col, lanes, k;
		pixel_t      px;
		w = 32'(cfg_width);
		if (w < 1) w = 1;
		if (w > MAX_W) w = MAX_W;
		h = 32'(cfg_height);
		if (h < 1) h = 1;
		if (h > MAX_H) h = MAX_H;
		// mode 3 runs as RGBA
		md = (cfg_mode > pngu_pkg::MODE_RGBA) ? pngu_pkg::MODE_RGBA : cfg_mode;
		lanes = (md == pngu_pkg::MODE_PALETTE) ? 1 : (md == pngu_pkg::MODE_RGB) ? 3 : 4;
		col = (col_cnt >= MAX_W) ? MAX_W - 1 : col_cnt;
		// outside the image every neighbor reads zero
		up  = (row_cnt == 0) ? '0 : above_mem[col];
		lft = (col == 0) ? '0 : left_px;
		ul  = (col == 0 || row_cnt == 0) ? '0 : ul_px;
		px.bad = (filt > pngu_pkg::FILT_PAETH);
		f = px.bad ? pngu_pkg::FILT_NONE : filt;
		rec = '0;
		for (k = 0; k < lanes; k++)
			rec[8*k +: 8] = unfilter_byte(f, raw[8*k +: 8], lft[8*k +: 8], up[8*k +: 8],
				ul[8*k +: 8]);
		if (md == pngu_pkg::MODE_RGB)
			rec[31:24] = pngu_pkg::ALPHA_OPAQUE;
		ul_px = up;
		left_px = rec;
		above_mem[col] = rec;
		// an 8-bit index always falls inside a full-size palette
		colour = (md == pngu_pkg::MODE_PALETTE) ? palette_mem[rec[7:0]] : rec;
		px.red   = colour[7:0];
		px.green = colour[15:8];
		px.blue  = colour[23:16];
		px.alpha = colour[31:24];
		// counters survive a register change; a count past the new limit ends here
		px.rend = (col_cnt + 1 >= w);
		px.iend = px.rend && (row_cnt + 1 >= h);
		if (px.rend) begin
			col_cnt = 0;
			row_cnt = px.iend ? 0 : row_cnt + 1;
		end else begin
			col_cnt = col_cnt + 1;
		end
		recon_q.push_back(px);
	endtask

	task automatic apply_reg(input logic [pngu_pkg::CFG_IDX_W-1:0] idx,
			input logic [pngu_pkg::CFG_DATA_W-1:0] val);
		case (idx)
			pngu_pkg::CFG_COLOR_MODE:   cfg_mode = val[1:0];
			pngu_pkg::CFG_IMAGE_WIDTH:  cfg_width = val;
			pngu_pkg::CFG_IMAGE_HEIGHT: cfg_height = val;
			default: ;
		endcase
		n_cfg++;
	endtask

	task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			if (errors < REPORT_MAX)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
			errors++;
		end
	endtask

	task automatic check_pixel();
		pixel_t want;
		if (recon_q.size() == 0) begin
			if (errors < REPORT_MAX)
				$display("%0t: pixel transfer with none expected, actual %h %h %h %h %b%b%b",
					$time, out_red, out_green, out_blue, out_alpha, row_end, image_end,
					bad_filter);
			errors++;
		end else begin
			want = recon_q.pop_front();
			check_field("out_red", want.red, out_red);
			check_field("out_green", want.green, out_green);
			check_field("out_blue", want.blue, out_blue);
			check_field("out_alpha", want.alpha, out_alpha);
			check_field("row_end", 8'(want.rend), 8'(row_end));
			check_field("image_end", 8'(want.iend), 8'(image_end));
			check_field("bad_filter", 8'(want.bad), 8'(bad_filter));
			n_pixels++;
			n_rows += 32'(want.rend);
			n_images += 32'(want.iend);
			n_bad += 32'(want.bad);
		end
	endtask

	// ------------------------------------------------------------------
	// Monitor: everything sampled at the rising edge, pre-update values.
	// Output check runs before the input side so ordering never matters.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_valid && !in_stall;
			if (out_valid && !out_stall)
				check_pixel();
			if (in_valid && !in_stall) begin
				n_accepted++;
				if (cmd == CMD_PALETTE) begin
					palette_mem[entry_index] = {byte_alpha, byte_blue, byte_green, byte_red};
					n_pal_writes++;
				end else begin
					reconstruct_pixel(filter_type,
						{byte_alpha, byte_blue, byte_green, byte_red});
				end
			end
			if (in_valid && in_stall)
				n_in_stalled++;
			if (cfg_valid && cfg_ready)
				apply_reg(cfg_index, cfg_data);
			if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	// ------------------------------------------------------------------
	// Driver: presents the next queued item once the current one is taken.
	// Gaps are decided up front, never from in_stall.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (raw_q.size() != 0) begin
				drv_item = raw_q.pop_front();
				in_valid    <= 1'b1;
				cmd         <= drv_item.cmd;
				filter_type <= drv_item.filt;
				byte_red    <= drv_item.red;
				byte_green  <= drv_item.green;
				byte_blue   <= drv_item.blue;
				byte_alpha  <= drv_item.alpha;
				entry_index <= drv_item.slot;
				// idle burst after this transfer
				if (idle_on && $urandom_range(0, 7) == 0)
					send_gap = $urandom_range(1, 14);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold-off on request
	// that fills the pipeline and pushes back on the input.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			stall_left = LONG_HOLD;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 14) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Watchdog: a run with nothing moving for too long is hung.
	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("%0t: no transfer for %0d cycles, %0d pixels outstanding", $time,
			quiet_cycles, recon_q.size());
		$display("Verification failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------
	function automatic raw_item_t mk_item(input logic c, input logic [2:0] f,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input logic [7:0] a, input logic [7:0] s);
		raw_item_t it;
		it.cmd   = c;
		it.filt  = f;
		it.red   = r;
		it.green = g;
		it.blue  = b;
		it.alpha = a;
		it.slot  = s;
		return it;
	endfunction

	// Bytes lean toward the wrap-around corners.
	function automatic logic [7:0] rand_byte();
		int unsigned r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return 8'h00;
		else if (r == 1)
			return 8'hff;
		else
			return 8'($urandom);
	endfunction

	function automatic raw_item_t rand_item(input int unsigned pal_pct);
		raw_item_t it;
		it.cmd = ($urandom_range(0, 99) < pal_pct) ? CMD_PALETTE : CMD_PIXEL;
		if ($urandom_range(0, 9) == 0)
			it.filt = 3'($urandom_range(FILT_RSVD_5, FILT_RSVD_7));
		else
			it.filt = 3'($urandom_range(pngu_pkg::FILT_NONE, pngu_pkg::FILT_PAETH));
		it.red   = rand_byte();
		it.green = rand_byte();
		it.blue  = rand_byte();
		it.alpha = rand_byte();
		it.slot  = 8'($urandom);
		return it;
	endfunction

	// Image sides: mostly small so rows and images close often; now and then
	// zero, full size or beyond, which the DUT clamps.
	function automatic logic [pngu_pkg::CFG_DATA_W-1:0] pick_dim();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		else if (r == 1)
			return 11'd2047;
		else if (r == 2)
			return 11'(MAX_W);
		else if (r == 3)
			return 11'($urandom_range(13, 2047));
		else
			return 11'($urandom_range(1, 12));
	endfunction

	task automatic queue_item(input raw_item_t it);
		raw_q.push_back(it);
		n_issued++;
	endtask

	task automatic write_reg(input logic [pngu_pkg::CFG_IDX_W-1:0] idx,
			input logic [pngu_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Registers change only with the DUT drained. A palette write leaves no
	// trace on the output, so allow a few cycles after the last pixel.
	task automatic set_config(input logic [pngu_pkg::CFG_DATA_W-1:0] mode_v,
			input logic [pngu_pkg::CFG_DATA_W-1:0] width_v,
			input logic [pngu_pkg::CFG_DATA_W-1:0] height_v);
		while (n_accepted != n_issued || recon_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		write_reg(pngu_pkg::CFG_COLOR_MODE, mode_v);
		write_reg(pngu_pkg::CFG_IMAGE_WIDTH, width_v);
		write_reg(pngu_pkg::CFG_IMAGE_HEIGHT, height_v);
	endtask

	// ------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------
	initial begin
		int unsigned                     ph, n, k, pal_pct;
		logic [1:0]                      mode_pick;
		logic [pngu_pkg::CFG_DATA_W-1:0] mode_v;

		// shadow state matches the DUT reset
		cfg_mode   = pngu_pkg::COLOR_MODE_RST;
		cfg_width  = pngu_pkg::IMAGE_WIDTH_RST;
		cfg_height = pngu_pkg::IMAGE_HEIGHT_RST;
		for (k = 0; k < MAX_W; k++)
			above_mem[k] = '0;
		for (k = 0; k < pngu_pkg::PALETTE_SIZE_DEF; k++)
			palette_mem[k] = '0;
		left_px = '0;
		ul_px   = '0;
		col_cnt = 0;
		row_cnt = 0;
		idle_on = 1'b1;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: 3x2 RGBA image covering every filter, the wrap corners and
		// the reserved codes; an unused register slot is written and ignored.
		set_config(11'(pngu_pkg::MODE_RGBA), 11'd3, 11'd2);
		write_reg(CFG_IDX_SPARE, 11'h5a5);
		queue_item(mk_item(CMD_PALETTE, pngu_pkg::FILT_NONE, 8'hff, 8'hff, 8'hff, 8'hff,
			8'h00));
		queue_item(mk_item(CMD_PALETTE, pngu_pkg::FILT_NONE, 8'h12, 8'h34, 8'h56, 8'h78,
			8'hff));
		queue_item(mk_item(CMD_PALETTE, pngu_pkg::FILT_PAETH, 8'h00, 8'hff, 8'h00, 8'hff,
			8'h80));
		queue_item(mk_item(CMD_PIXEL, pngu_pkg::FILT_NONE, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00));
		queue_item(mk_item(CMD_PIXEL, pngu_pkg::FILT_SUB, 8'h01, 8'h01, 8'h01, 8'h01, 8'hff));
		queue_item(mk_item(CMD_PIXEL, pngu_pkg::FILT_UP, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00));
		queue_item(mk_item(CMD_PIXEL, pngu_pkg::FILT_AVG, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00));
		queue_item(mk_item(CMD_PIXEL, pngu_pkg::FILT_PAETH, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00));
		queue_item(mk_item(CMD_PIXEL, FILT_RSVD_7, 8'h5a, 8'ha5, 8'h3c, 8'hc3, 8'h00));
		queue_item(mk_item(CMD_PIXEL, FILT_RSVD_5, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		queue_item(mk_item(CMD_PIXEL, FILT_RSVD_6, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
		queue_item(mk_item(CMD_PIXEL, pngu_pkg::FILT_SUB, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));

		// RGB with junk above the mode bits; height 0 clamps to one row.
		set_config({9'h1ff, pngu_pkg::MODE_RGB}, 11'd2, 11'd0);
		queue_item(mk_item(CMD_PIXEL, pngu_pkg::FILT_PAETH, 8'hff, 8'hff, 8'hff, 8'hff,
			8'h00));
		queue_item(mk_item(CMD_PIXEL, pngu_pkg::FILT_AVG, 8'h7f, 8'h7f, 8'h7f, 8'h00, 8'h00));
		queue_item(mk_item(CMD_PIXEL, pngu_pkg::FILT_UP, 8'h01, 8'h02, 8'h03, 8'h04, 8'h00));
		queue_item(mk_item(CMD_PIXEL, pngu_pkg::FILT_SUB, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00));

		// Palette lookups at both ends of the index; width 2047 clamps to full.
		set_config(11'(pngu_pkg::MODE_PALETTE), 11'd2047, 11'd2);
		queue_item(mk_item(CMD_PIXEL, pngu_pkg::FILT_NONE, 8'h00, 8'h11, 8'h22, 8'h33, 8'h00));
		queue_item(mk_item(CMD_PIXEL, pngu_pkg::FILT_SUB, 8'hff, 8'hee, 8'hdd, 8'hcc, 8'h00));
		queue_item(mk_item(CMD_PIXEL, pngu_pkg::FILT_NONE, 8'h80, 8'h00, 8'hff, 8'h00, 8'h00));

		// Mode 3 runs as RGBA; width 0 clamps to one column.
		set_config(11'(MODE_SPARE), 11'd0, 11'd1);
		queue_item(mk_item(CMD_PIXEL, pngu_pkg::FILT_PAETH, 8'hff, 8'h00, 8'hff, 8'h00,
			8'h00));
		queue_item(mk_item(CMD_PIXEL, pngu_pkg::FILT_UP, 8'h10, 8'h20, 8'h30, 8'h40, 8'h00));
		queue_item(mk_item(CMD_PIXEL, FILT_RSVD_5, 8'h01, 8'hfe, 8'h7f, 8'h80, 8'h00));

		// Random phases: new settings each time, mostly pixel streams with
		// palette writes mixed in; idling toggled per phase.
		ph = 0;
		while (n_issued < ITEM_TARGET - CALM_ITEMS) begin
			mode_pick = 2'($urandom_range(0, 3));
			mode_v = (($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 511)) << 2 : '0)
				| 11'(mode_pick);
			set_config(mode_v, pick_dim(), pick_dim());
			idle_on = ($urandom_range(0, 3) != 0);
			pal_pct = (mode_pick == pngu_pkg::MODE_PALETTE) ? 20 : 5;
			n = (ph == HOLD_PHASE) ? 150 : $urandom_range(20, 120);
			for (k = 0; k < n; k++)
				queue_item(rand_item(pal_pct));
			// long output hold-off while the sender keeps offering
			if (ph == HOLD_PHASE)
				hold_req = 1'b1;
			ph++;
		end

		// Final stretch with both sides running flat out.
		set_config(11'($urandom_range(0, 3)), 11'($urandom_range(1, 12)),
			11'($urandom_range(1, 6)));
		idle_on = 1'b0;
		for (k = 0; k < CALM_ITEMS; k++)
			queue_item(rand_item(5));

		while (n_accepted != n_issued || recon_q.size() != 0)
			@(posedge clk);
		repeat (2 * SETTLE) @(posedge clk);
		if (recon_q.size() != 0) begin
			$display("%0t: %0d pixels never arrived", $time, recon_q.size());
			errors++;
		end

		$display("Covered %0d pixels, %0d palette writes, %0d register writes over %0d phases.",
			n_pixels, n_pal_writes, n_cfg, ph + 5);
		$display("Saw %0d row ends, %0d image ends, %0d bad filter codes; input held %0d cycles.",
			n_rows, n_images, n_bad, n_in_stalled);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
